// ----- sv/stq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted timer queue.
// Used by stq_cell, stq_deadline and sorted_timer_queue; depends on nothing.
package stq_pkg;

  // Width of one deadline and of the free-running counter.
  localparam int DEADLINE_W = 64;
  localparam int DELAY_W    = 32;
  localparam int TPS_W      = 32;
  localparam int HELD_W     = 5;
  localparam int STATUS_W   = 2;

  // Default queue depth and reset value of the counter frequency.
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam logic [TPS_W-1:0] TPS_RESET = 32'd62500000;

  // Command codes on func.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_EXPIRE = 1'b1;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_APPLY
  } state_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

// ----- sv/sorted_timer_queue.sv -----
`timescale 1ns / 1ps
// Sorted timer queue top level: sequencer, chain of deadline cells, result.
// Depends on stq_pkg, stq_deadline and stq_cell.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+---------------------------------------
//   command  | start, busy             | func, delay_seconds, now_tick
//   result   | done (one-cycle strobe) | reprogram, interval_ticks, irq_enable,
//            |                         | status, entries_held
//   config   | ticks_we                | ticks_per_second
//
// An accepted command is captured, then passes the multiply state, the
// 64-bit add state and the apply state, which does the compare and shift
// across the cell chain and registers the result. busy is high in the
// working states, so a new command is taken only after the apply state.
// Reset clears the count, interrupt enable and sequencer; deadlines are
// valid only below the count. Result beats cannot be stalled.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [stq_pkg::DELAY_W-1:0]     delay_seconds,
  input  logic [stq_pkg::DEADLINE_W-1:0]  now_tick,
  output logic                            done,
  output logic                            reprogram,
  output logic [stq_pkg::DEADLINE_W-1:0]  interval_ticks,
  output logic                            irq_enable,
  output logic [stq_pkg::STATUS_W-1:0]    status,
  output logic [stq_pkg::HELD_W-1:0]      entries_held,
  input  logic                            ticks_we,
  input  logic [stq_pkg::TPS_W-1:0]       ticks_per_second
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t state;
  state_t state_next;

  logic                  load;
  logic                  apply;
  logic [TPS_W-1:0]      tps;
  logic                  func_q;
  logic [DELAY_W-1:0]    delay_q;
  logic [DEADLINE_W-1:0] now_q;
  logic [DEADLINE_W-1:0] deadline;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  irq_on;
  logic                  irq_on_next;
  cell_ctrl_t            ctrl;
  logic                  reprogram_next;
  logic [DEADLINE_W-1:0] head_next;
  logic [DEADLINE_W-1:0] interval_next;
  logic [STATUS_W-1:0]   status_next;

  logic [DEADLINE_W-1:0] cell_value [QUEUE_DEPTH];
  logic                  cell_gt    [QUEUE_DEPTH];

  // Counter frequency register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (ticks_we) begin
      tps <= ticks_per_second;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_MUL : S_IDLE;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b1;
    load  = 1'b0;
    apply = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        load = start;
      end
      S_APPLY: apply = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Command beat capture.
  always_ff @(posedge clk) begin
    if (load) begin
      func_q  <= func;
      delay_q <= delay_seconds;
      now_q   <= now_tick;
    end
  end

  stq_deadline u_deadline (
    .clk              (clk),
    .delay_seconds    (delay_q),
    .ticks_per_second (tps),
    .now_tick         (now_q),
    .deadline         (deadline)
  );

  // Queue update and result of one command.
  always_comb begin
    ctrl           = '0;
    count_next     = count;
    irq_on_next    = irq_on;
    reprogram_next = 1'b0;
    head_next      = deadline;
    status_next    = ST_OK;
    if (func_q == FUNC_ADD) begin
      if (count == CNT_W'(QUEUE_DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        ctrl.insert = apply;
        count_next  = count + 1'b1;
        if (count == '0 || cell_gt[0]) begin
          irq_on_next    = 1'b1;
          reprogram_next = 1'b1;
        end
      end
    end else begin
      head_next = cell_value[1];
      if (count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        ctrl.pop   = apply;
        count_next = count - 1'b1;
        if (count_next != '0) begin
          reprogram_next = 1'b1;
        end else begin
          irq_on_next = 1'b0;
        end
      end
    end
  end

  // Interval to the new head, saturated at zero.
  always_comb begin
    interval_next = '0;
    if (reprogram_next && (head_next > now_q)) begin
      interval_next = head_next - now_q;
    end
  end

  // Chain of deadline cells.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic [DEADLINE_W-1:0] left_v;
    logic                  left_g;
    logic [DEADLINE_W-1:0] right_v;

    if (gi == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_inner
      assign left_v = cell_value[gi-1];
      assign left_g = cell_gt[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign right_v = cell_value[gi];
    end else begin : g_body
      assign right_v = cell_value[gi+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (count > CNT_W'(gi)),
      .at_tail     (count == CNT_W'(gi)),
      .deadline    (deadline),
      .left_value  (left_v),
      .left_gt     (left_g),
      .right_value (right_v),
      .value       (cell_value[gi]),
      .gt          (cell_gt[gi])
    );
  end

  // Count, interrupt enable and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      irq_on <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= apply;
      if (apply) begin
        count  <= count_next;
        irq_on <= irq_on_next;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (apply) begin
      reprogram      <= reprogram_next;
      interval_ticks <= interval_next;
      irq_enable     <= irq_on_next;
      status         <= status_next;
      entries_held   <= HELD_W'(count_next);
    end
  end

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // A result beat follows exactly one apply cycle.
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_APPLY)
    else $error("result beat without apply cycle");

  // A reload request always comes with the interrupt enabled.
  a_reprogram_irq: assert property (@(posedge clk) disable iff (rst)
    done && reprogram |-> irq_enable)
    else $error("reload requested with interrupt off");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted but block not busy");

  // A rejected command leaves the queue untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> $stable(count))
    else $error("rejected command changed the count");

endmodule

// ----- sv/stq_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted deadline chain: holds one deadline and trades it
// with its neighbors on insert and pop. Depends on stq_pkg.
module stq_cell (
  input  logic                            clk,
  input  stq_pkg::cell_ctrl_t             ctrl,
  input  logic                            valid,
  input  logic                            at_tail,
  input  logic [stq_pkg::DEADLINE_W-1:0]  deadline,
  input  logic [stq_pkg::DEADLINE_W-1:0]  left_value,
  input  logic                            left_gt,
  input  logic [stq_pkg::DEADLINE_W-1:0]  right_value,
  output logic [stq_pkg::DEADLINE_W-1:0]  value,
  output logic                            gt
);
  import stq_pkg::*;

  logic [DEADLINE_W-1:0] value_next;

  // A held deadline strictly later than the new one moves one place back.
  assign gt = valid && (value > deadline);

  // Take the left neighbor, the new deadline, or the right neighbor.
  always_comb begin
    value_next = value;
    if (ctrl.insert) begin
      if (left_gt) begin
        value_next = left_value;
      end else if (gt || at_tail) begin
        value_next = deadline;
      end
    end else if (ctrl.pop) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- sv/stq_deadline.sv -----
`timescale 1ns / 1ps
// Two-stage deadline unit: delay times frequency, then plus the current tick.
// Depends on stq_pkg.
module stq_deadline (
  input  logic                            clk,
  input  logic [stq_pkg::DELAY_W-1:0]     delay_seconds,
  input  logic [stq_pkg::TPS_W-1:0]       ticks_per_second,
  input  logic [stq_pkg::DEADLINE_W-1:0]  now_tick,
  output logic [stq_pkg::DEADLINE_W-1:0]  deadline
);
  import stq_pkg::*;

  logic [DEADLINE_W-1:0] product;

  // The 32 by 32 product fits 64 bits; the sum wraps modulo 2^64.
  always_ff @(posedge clk) begin
    product  <= DEADLINE_W'(delay_seconds) * DEADLINE_W'(ticks_per_second);
    deadline <= now_tick + product;
  end

endmodule

// ----- tb/sv/sorted_timer_queue_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_timer_queue: directed corner cases, then random
// add/expire traffic over several counter frequencies. Depends on stq_pkg and the RTL.
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam logic [DEADLINE_W-1:0] TICK_MAX = {DEADLINE_W{1'b1}};
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  // One result beat as the block reports it.
  typedef struct packed {
    logic                  reprogram;
    logic [DEADLINE_W-1:0] interval;
    logic                  irq;
    logic [STATUS_W-1:0]   status;
    logic [HELD_W-1:0]     held;
  } timer_result_t;

  // Keeps a sorted copy of the deadline queue and the results it implies.
  class deadline_scoreboard;
    logic [TPS_W-1:0]      tps;
    logic [DEADLINE_W-1:0] deadlines [DEPTH];
    int                    held;
    logic                  irq_on;
    timer_result_t         expected_beats [$];
    int                    mismatch_count;

    function new();
      tps = TPS_RESET;
      held = 0;
      irq_on = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_rate(logic [TPS_W-1:0] rate);
      tps = rate;
    endfunction

    function logic [DEADLINE_W-1:0] gap_to(logic [DEADLINE_W-1:0] deadline,
                                           logic [DEADLINE_W-1:0] now);
      return (deadline > now) ? deadline - now : '0;
    endfunction

    // Apply one accepted command to the queue copy and queue its result.
    function void note_command(logic f, logic [DELAY_W-1:0] delay,
                               logic [DEADLINE_W-1:0] now);
      timer_result_t         beat;
      logic [DEADLINE_W-1:0] deadline;
      int                    pos;
      int                    i;
      beat = '0;
      beat.status = ST_OK;
      if (f == FUNC_ADD) begin
        if (held >= DEPTH) begin
          beat.status = ST_FULL;
        end else begin
          deadline = now + {32'd0, delay} * {32'd0, tps};
          // Later deadlines move up one slot; equal ones stay ahead.
          pos = held;
          while (pos > 0 && deadlines[pos-1] > deadline) begin
            deadlines[pos] = deadlines[pos-1];
            pos--;
          end
          deadlines[pos] = deadline;
          held++;
          if (pos == 0) begin
            irq_on = 1'b1;
            beat.reprogram = 1'b1;
            beat.interval = gap_to(deadline, now);
          end
        end
      end else begin
        if (held == 0) begin
          beat.status = ST_EMPTY;
        end else begin
          for (i = 1; i < held; i++) deadlines[i-1] = deadlines[i];
          held--;
          if (held > 0) begin
            beat.reprogram = 1'b1;
            beat.interval = gap_to(deadlines[0], now);
          end else begin
            irq_on = 1'b0;
          end
        end
      end
      beat.irq = irq_on;
      beat.held = held[HELD_W-1:0];
      expected_beats.push_back(beat);
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    // Only the first 40 mismatches are printed; all are counted.
    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Compare a result beat with the oldest expectation, field by field.
    task check_result(timer_result_t got);
      timer_result_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = expected_beats.pop_front();
        if (got.reprogram !== want.reprogram)
          report_mismatch($sformatf("reprogram %b, expected %b", got.reprogram, want.reprogram));
        if (got.interval !== want.interval)
          report_mismatch($sformatf("interval_ticks %h, expected %h",
                                    got.interval, want.interval));
        if (got.irq !== want.irq)
          report_mismatch($sformatf("irq_enable %b, expected %b", got.irq, want.irq));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.held !== want.held)
          report_mismatch($sformatf("entries_held %0d, expected %0d", got.held, want.held));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  func;
  logic [DELAY_W-1:0]    delay_seconds;
  logic [DEADLINE_W-1:0] now_tick;
  logic                  done;
  logic                  reprogram;
  logic [DEADLINE_W-1:0] interval_ticks;
  logic                  irq_enable;
  logic [STATUS_W-1:0]   status;
  logic [HELD_W-1:0]     entries_held;
  logic                  ticks_we;
  logic [TPS_W-1:0]      ticks_per_second;

  deadline_scoreboard sb = new();
  timer_result_t      seen_beat;

  sorted_timer_queue uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .func             (func),
    .delay_seconds    (delay_seconds),
    .now_tick         (now_tick),
    .done             (done),
    .reprogram        (reprogram),
    .interval_ticks   (interval_ticks),
    .irq_enable       (irq_enable),
    .status           (status),
    .entries_held     (entries_held),
    .ticks_we         (ticks_we),
    .ticks_per_second (ticks_per_second)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("sorted_timer_queue test failed");
    $finish;
  end

  // Every result beat is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_beat = {reprogram, interval_ticks, irq_enable, status, entries_held};
      sb.check_result(seen_beat);
    end
  end

  // Present one command and hold it until the block takes the beat.
  task automatic issue(logic f, logic [DELAY_W-1:0] d, logic [DEADLINE_W-1:0] n);
    @(negedge clk);
    start = 1'b1;
    func = f;
    delay_seconds = d;
    now_tick = n;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(f, d, n);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Idle cycles with junk on the command fields, which must be ignored.
  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      func = 1'($urandom);
      delay_seconds = $urandom;
      now_tick = {$urandom, $urandom};
    end
  endtask

  // Wait until every expected beat has come back, plus a little margin.
  task automatic settle();
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [TPS_W-1:0] rate);
    @(negedge clk);
    ticks_we = 1'b1;
    ticks_per_second = rate;
    @(posedge clk);
    sb.set_rate(rate);
    @(negedge clk);
    ticks_we = 1'b0;
    ticks_per_second = $urandom;
  endtask

  // Random traffic that swings the queue between empty and full.
  logic [DEADLINE_W-1:0] clock_now;
  logic [DELAY_W-1:0]    last_delay;
  logic [DEADLINE_W-1:0] last_now;

  task automatic run_phase(int count);
    bit                    filling;
    bit                    quiet;
    int                    r;
    int                    gap;
    logic                  f;
    logic [DELAY_W-1:0]    d;
    logic [DEADLINE_W-1:0] n;
    filling = (sb.held < DEPTH);
    quiet = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (sb.held >= DEPTH) filling = 1'b0;
      else if (sb.held == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      f = filling ? ((r < 75) ? FUNC_ADD : FUNC_EXPIRE)
                  : ((r < 75) ? FUNC_EXPIRE : FUNC_ADD);
      // Counter value: mostly advancing, sometimes in the past, random or near wrap.
      r = $urandom_range(0, 99);
      if (r < 65) begin
        clock_now = clock_now + DEADLINE_W'($urandom_range(0, 3000));
        n = clock_now;
      end else if (r < 80) begin
        n = clock_now - DEADLINE_W'($urandom_range(0, 3000));
      end else if (r < 93) begin
        n = {$urandom, $urandom};
      end else begin
        n = TICK_MAX - DEADLINE_W'($urandom_range(0, 1000));
      end
      r = $urandom_range(0, 99);
      if (r < 35) d = $urandom_range(0, 5);
      else if (r < 45) d = DELAY_MAX - $urandom_range(0, 3);
      else d = $urandom;
      // Repeating an earlier add produces equal deadlines.
      if (f == FUNC_ADD && $urandom_range(0, 9) == 0) begin
        d = last_delay;
        n = last_now;
      end
      if (f == FUNC_ADD) begin
        last_delay = d;
        last_now = n;
      end
      r = $urandom_range(0, 99);
      if (quiet || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      issue(f, d, n);
      idle(gap);
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ADD;
    delay_seconds = '0;
    now_tick = '0;
    ticks_we = 1'b0;
    ticks_per_second = '0;
    clock_now = 64'd5000;
    last_delay = '0;
    last_now = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset frequency.
    issue(FUNC_EXPIRE, 32'd0, 64'd0);        // expire on an empty queue
    issue(FUNC_ADD, 32'd0, 64'd100);         // head equal to now: interval saturates
    issue(FUNC_EXPIRE, 32'd0, 64'd100);      // queue empties, interrupt off
    issue(FUNC_ADD, 32'd2, 64'd1000);        // new head
    issue(FUNC_ADD, 32'd2, 64'd1000);        // equal deadline goes behind
    idle(2);
    issue(FUNC_ADD, 32'd1, 64'd1000);        // strictly earlier: new head
    issue(FUNC_ADD, DELAY_MAX, TICK_MAX);    // deadline wraps past 2^64
    issue(FUNC_ADD, 32'd0, TICK_MAX);        // largest deadline, goes to the tail
    issue(FUNC_EXPIRE, 32'd0, 64'd0);
    idle(5);
    issue(FUNC_EXPIRE, 32'd0, TICK_MAX);     // head already passed: interval saturates
    for (i = 0; i < 13; i++)
      issue(FUNC_ADD, DELAY_W'($urandom_range(0, 100)),
            DEADLINE_W'($urandom_range(0, 5000)));
    issue(FUNC_ADD, DELAY_MAX, 64'd7);       // queue full: dropped

    // Random part, one phase per counter frequency; the block drains before each write.
    settle();
    configure(32'd1);
    run_phase(185);
    settle();
    configure(32'hFFFF_FFFF);
    run_phase(185);
    settle();
    configure(32'd7);
    run_phase(185);
    settle();
    configure($urandom_range(1, 32'hFFFF_FFFF));
    run_phase(185);
    settle();
    configure(TPS_RESET);
    run_phase(185);

    settle();
    if (sb.outstanding() != 0) sb.report_mismatch("expected beats left over at the end");
    if (sb.mismatch_count == 0) begin
      $display("sorted_timer_queue test passed");
    end else begin
      $display("sorted_timer_queue test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/stq_pkg.sv
sv/stq_cell.sv
sv/stq_deadline.sv
sv/sorted_timer_queue.sv
tb/sv/sorted_timer_queue_tb.sv
